[src/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU frame replacement package
// Shared widths, types and request codes of the LRU frame replacement block.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int FRAME_W = 10;
    localparam int TDATA_W = 16;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic {
        FUNC_REF   = 1'b0,
        FUNC_EVICT = 1'b1
    } func_t;

endpackage

[src/lfr_ram.sv]
// ----------------------------------------------------------------------------
// LRU frame replacement RAM
// Generic single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/lru_frame_replacement.sv]
// ----------------------------------------------------------------------------
// LRU frame replacement
// Exact least-recently-used order over page frames, kept as a doubly linked
// recency list in link memories.
// ----------------------------------------------------------------------------
// A request either references a frame (s_tuser = 0), moving it to the
// most-recent end of the list, or evicts the least-recent frame (s_tuser = 1),
// which returns one result with its number, or with m_tuser set when the list
// is empty. References give no result, and a reference to a frame of FRAMES or
// more is dropped. The presence marks sit beside the older links in one
// memory. After reset the block clears them, one entry per cycle, over all
// min(FRAMES, 1024) entries with s_tready low. Then a reference is accepted,
// reading the frame's links and presence mark, is unlinked, and writes the
// new head links in S_PUSH_SELF and S_PUSH_LINK, since the newer-link memory
// takes one write per cycle; S_PUSH_LINK is skipped when the list is empty
// after the unlink. An eviction unlinks the tail frame, then registers its
// result (with no unlink when empty); a dropped reference stays idle. The
// result register lets the next request in while a result waits on m_tready.
module lru_frame_replacement import lfr_pkg::*; #(
    parameter int FRAMES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [9:0] frame_index
    input  logic [0:0]         s_tuser,   // [0] func
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [9:0] victim_frame
    output logic [0:0]         m_tuser    // [0] list_empty
);

    localparam int DEPTH = (FRAMES < (2 ** FRAME_W)) ? FRAMES : (2 ** FRAME_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(DEPTH + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [OW-1:0] occ_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UNLINK,
        S_PUSH_SELF,
        S_PUSH_LINK,
        S_RESULT
    } state_t;

    state_t state_reg;
    addr_t  clr_reg;
    func_t  func_reg;
    addr_t  addr_reg;
    addr_t  head_reg;
    addr_t  tail_reg;
    occ_t   occ_reg;
    logic   m_tvalid_reg;
    addr_t  m_victim_reg;
    logic   m_empty_reg;
    addr_t  res_victim_reg;
    logic   res_empty_reg;

    frame_t s_frame;
    func_t  s_func;
    logic   s_accept;
    logic   frame_ok;
    logic   out_free;

    addr_t       rd_addr;
    logic        newer_we;
    addr_t       newer_waddr;
    addr_t       newer_wdata;
    addr_t       newer_rdata;
    logic        older_we;
    addr_t       older_waddr;
    logic [AW:0] older_wdata;
    logic [AW:0] older_rdata;
    addr_t       older_link;
    logic        inl_rdata;

    assign s_frame  = s_tdata[FRAME_W-1:0];
    assign s_func   = func_t'(s_tuser[0]);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign frame_ok = ({22'd0, s_frame} < 32'(FRAMES));
    assign out_free = !m_tvalid_reg || m_tready;

    assign older_link = older_rdata[AW-1:0];
    assign inl_rdata  = older_rdata[AW];

    assign rd_addr = (state_reg == S_IDLE)
                   ? ((s_func == FUNC_EVICT) ? tail_reg : s_frame[AW-1:0])
                   : addr_reg;

    always_comb begin
        newer_we    = 1'b0;
        newer_waddr = addr_reg;
        newer_wdata = addr_reg;
        older_we    = 1'b0;
        older_waddr = addr_reg;
        older_wdata = {1'b0, addr_reg};
        unique case (state_reg)
            S_CLEAR: begin
                older_we    = 1'b1;
                older_waddr = clr_reg;
                older_wdata = '0;
            end
            S_UNLINK: begin
                older_we    = inl_rdata && (addr_reg != head_reg);
                older_waddr = newer_rdata;
                older_wdata = {1'b1, older_link};
                newer_we    = inl_rdata && (addr_reg != tail_reg);
                newer_waddr = older_link;
                newer_wdata = newer_rdata;
            end
            S_PUSH_SELF: begin
                newer_we    = 1'b1;
                older_we    = 1'b1;
                older_wdata = {1'b1, ((occ_reg == '0) ? addr_reg : head_reg)};
            end
            S_PUSH_LINK: begin
                newer_we    = 1'b1;
                newer_waddr = head_reg;
            end
            S_RESULT: begin
                older_we    = !res_empty_reg;
                older_wdata = {1'b0, addr_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_RESULT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + addr_t'(1);
                    if (clr_reg == addr_t'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        func_reg <= s_func;
                        addr_reg <= rd_addr;
                        if (s_func == FUNC_EVICT) begin
                            if (occ_reg == '0) begin
                                res_victim_reg <= '0;
                                res_empty_reg  <= 1'b1;
                                state_reg      <= S_RESULT;
                            end else begin
                                state_reg <= S_UNLINK;
                            end
                        end else if (frame_ok) begin
                            state_reg <= S_UNLINK;
                        end
                    end
                end
                S_UNLINK: begin
                    if (inl_rdata) begin
                        if (addr_reg == head_reg) begin
                            head_reg <= older_link;
                        end
                        if (addr_reg == tail_reg) begin
                            tail_reg <= newer_rdata;
                        end
                        if (occ_reg != '0) begin
                            occ_reg <= occ_reg - occ_t'(1);
                        end
                    end
                    if (func_reg == FUNC_EVICT) begin
                        res_victim_reg <= addr_reg;
                        res_empty_reg  <= 1'b0;
                        state_reg      <= S_RESULT;
                    end else begin
                        state_reg <= S_PUSH_SELF;
                    end
                end
                S_PUSH_SELF: begin
                    if (occ_reg == '0) begin
                        head_reg  <= addr_reg;
                        tail_reg  <= addr_reg;
                        occ_reg   <= occ_t'(1);
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_PUSH_LINK;
                    end
                end
                S_PUSH_LINK: begin
                    head_reg  <= addr_reg;
                    occ_reg   <= occ_reg + occ_t'(1);
                    state_reg <= S_IDLE;
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_victim_reg <= res_victim_reg;
                        m_empty_reg  <= res_empty_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lfr_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_newer_ram (
        .aclk    (aclk),
        .wr_en   (newer_we),
        .wr_addr (newer_waddr),
        .wr_data (newer_wdata),
        .rd_addr (rd_addr),
        .rd_data (newer_rdata)
    );

    lfr_ram #(
        .WIDTH (AW + 1),
        .DEPTH (DEPTH)
    ) u_older_ram (
        .aclk    (aclk),
        .wr_en   (older_we),
        .wr_addr (older_waddr),
        .wr_data (older_wdata),
        .rd_addr (rd_addr),
        .rd_data (older_rdata)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = TDATA_W'(m_victim_reg);
    assign m_tuser[0] = m_empty_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= occ_t'(DEPTH))
        else $error("Occupancy exceeds the number of frames.");

    a_empty_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("Empty result carries a nonzero victim.");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT) && m_tvalid_reg && !m_tready
        |=> (state_reg == S_RESULT) && m_tvalid_reg)
        else $error("Result register overwritten while stalled.");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready && !m_tvalid_reg)
        else $error("Request handled during the clearing pass.");

endmodule
